### src/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types, result codes and helpers of the timed counting semaphore.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int TMR_W    = 17;
  localparam int TAIL_W   = 6;
  localparam logic [TMR_W-1:0] TMR_UNLIMITED = 17'h10000;

  localparam logic [1:0] ACT_WAIT   = 2'd0;
  localparam logic [1:0] ACT_SIGNAL = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  localparam logic [2:0] KIND_ACQ   = 3'd0;
  localparam logic [2:0] KIND_BLOCK = 3'd1;
  localparam logic [2:0] KIND_SIG   = 3'd2;
  localparam logic [2:0] KIND_TIME  = 3'd3;
  localparam logic [2:0] KIND_DONE  = 3'd4;
  localparam logic [2:0] KIND_FULL  = 3'd5;

  localparam logic CFG_IDX_INIT = 1'b0;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_DEC,
    OP_POP,
    OP_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [TAIL_W-1:0] tail;
  } cell_cmd_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### src/tcs_in_if.sv
// ----------------------------------------------------------------------------
// tcs_in_if
// Request channel: wait, signal or tick items.
// ----------------------------------------------------------------------------
interface tcs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [7:0]         thread_id;
  logic [15:0]        timeout_ticks;
  logic signed [15:0] release_count;

  modport source (output valid, action, thread_id, timeout_ticks, release_count,
                  input ready);
  modport sink   (input valid, action, thread_id, timeout_ticks, release_count,
                  output ready);
endinterface

### src/tcs_out_if.sv
// ----------------------------------------------------------------------------
// tcs_out_if
// Result channel: acquired, blocked, full, released, timed-out and done items.
// ----------------------------------------------------------------------------
interface tcs_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [7:0]         released_id;
  logic signed [15:0] return_value;
  logic signed [15:0] count_now;
  logic               last;

  modport source (output valid, kind, released_id, return_value, count_now, last,
                  input ready);
  modport sink   (input valid, kind, released_id, return_value, count_now, last,
                  output ready);
endinterface

### src/tcs_cell.sv
// ----------------------------------------------------------------------------
// tcs_cell
// One waiter slot: thread id, timer and expiry flag; shifts toward the head.
// ----------------------------------------------------------------------------
module tcs_cell
  import tcs_pkg::*;
#(
  parameter int ID_BITS = 8,
  parameter int INDEX   = 0
) (
  input  logic               clk,
  input  cell_cmd_t          cmd,
  input  logic [ID_BITS-1:0] new_id,
  input  logic [TMR_W-1:0]   new_tmr,
  input  logic [ID_BITS-1:0] nb_id,
  input  logic [TMR_W-1:0]   nb_tmr,
  input  logic               nb_exp,
  input  logic [ID_BITS-1:0] hd_id,
  input  logic [TMR_W-1:0]   hd_tmr,
  input  logic               hd_exp,
  output logic [ID_BITS-1:0] id,
  output logic [TMR_W-1:0]   tmr,
  output logic               exp
);

  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [TMR_W-1:0]   tmr_r, tmr_nxt;
  logic               exp_r, exp_nxt;
  logic               is_tail;

  assign is_tail = (cmd.tail == TAIL_W'(INDEX));

  always_comb begin
    id_nxt  = id_r;
    tmr_nxt = tmr_r;
    exp_nxt = exp_r;
    unique case (cmd.op)
      OP_HOLD: ;
      OP_LOAD: begin
        if (is_tail) begin
          id_nxt  = new_id;
          tmr_nxt = new_tmr;
        end
      end
      OP_DEC: begin
        if (tmr_r != TMR_UNLIMITED) begin
          tmr_nxt = tmr_r - TMR_W'(1);
        end
        exp_nxt = (tmr_r != TMR_UNLIMITED) && (tmr_r <= TMR_W'(1));
      end
      OP_POP: begin
        id_nxt  = nb_id;
        tmr_nxt = nb_tmr;
        exp_nxt = nb_exp;
      end
      OP_ROT: begin
        // tail slot takes the head, the rest advance
        if (is_tail) begin
          id_nxt  = hd_id;
          tmr_nxt = hd_tmr;
          exp_nxt = hd_exp;
        end else begin
          id_nxt  = nb_id;
          tmr_nxt = nb_tmr;
          exp_nxt = nb_exp;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    tmr_r <= tmr_nxt;
    exp_r <= exp_nxt;
  end

  assign id  = id_r;
  assign tmr = tmr_r;
  assign exp = exp_r;

endmodule

### src/timed_counting_semaphore.sv
// ----------------------------------------------------------------------------
// timed_counting_semaphore
// Counting semaphore with a queue of blocked threads and per-waiter timeouts.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one item at a time (wait, signal or tick); in_ready is high
//   only while the block is idle. out_ch carries the result items of that
//   item, the final one flagged by last. cfg_* is an APB write/read port for
//   initial_count at address 0; a write loads the count at once.
// Sequence: wait: its single result. signal: one result per released
//   waiter, then done. tick: S_TDEC decrements the timers, S_TCNT adds
//   expired waiters to the count, then S_SCAN checks the head cell and
//   pops or rotates it to the tail once per queued waiter, then done.
//   The next item is taken the cycle after the last result is loaded.
// Reset: count returns to 1 (initial_count resets to 1), the queue empties.
// Stall: a result held in the output register waits for out_ready; the
//   queue sequencer holds each new result until the register is free.
// ----------------------------------------------------------------------------
module timed_counting_semaphore
  import tcs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  tcs_in_if.sink       in_ch,
  tcs_out_if.source    out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WAIT = 7'b0000010,
    S_SIG  = 7'b0000100,
    S_TDEC = 7'b0001000,
    S_TCNT = 7'b0010000,
    S_SCAN = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [15:0] init_r, count_r, count_nxt;
  logic [CW-1:0]      wc_r, wc_nxt;
  logic [CW-1:0]      left_r, left_nxt;
  logic [ID_BITS-1:0] id_r;
  logic [15:0]        tmo_r;
  logic signed [15:0] ret_r, ret_nxt;

  logic               out_valid_r;
  logic [2:0]         kind_r;
  logic [7:0]         rid_r;
  logic signed [15:0] oret_r, ocnt_r;
  logic               last_r;

  logic               emit, slot_free;
  logic [2:0]         e_kind;
  logic [7:0]         e_id;
  logic signed [15:0] e_ret;
  logic               e_last;

  cell_cmd_t          cmd;
  logic [ID_BITS-1:0] id_a  [QUEUE_DEPTH];
  logic [TMR_W-1:0]   tmr_a [QUEUE_DEPTH];
  logic               exp_a [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] exp_vec;
  logic [TMR_W-1:0]   new_tmr;
  logic               cfg_wr;
  logic               accept;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == CFG_IDX_INIT);
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_INIT) ? 32'(init_r) : 32'd0;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && (state_r == S_IDLE);
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign new_tmr     = (tmo_r == 16'd0) ? TMR_UNLIMITED : TMR_W'(tmo_r);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam int NB = (i + 1 < QUEUE_DEPTH) ? i + 1 : 0;
    tcs_cell #(.ID_BITS(ID_BITS), .INDEX(i)) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .new_id  (id_r),
      .new_tmr (new_tmr),
      .nb_id   (id_a[NB]),
      .nb_tmr  (tmr_a[NB]),
      .nb_exp  (exp_a[NB]),
      .hd_id   (id_a[0]),
      .hd_tmr  (tmr_a[0]),
      .hd_exp  (exp_a[0]),
      .id      (id_a[i]),
      .tmr     (tmr_a[i]),
      .exp     (exp_a[i])
    );
    assign exp_vec[i] = exp_a[i] && (CW'(i) < wc_r);
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    wc_nxt    = wc_r;
    left_nxt  = left_r;
    ret_nxt   = ret_r;
    cmd       = '{op: OP_HOLD, tail: '0};
    emit      = 1'b0;
    e_kind    = KIND_DONE;
    e_id      = 8'd0;
    e_ret     = 16'sd0;
    e_last    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ret_nxt  = 16'sd0;
          left_nxt = '0;
          unique case (in_ch.action)
            ACT_WAIT: state_nxt = S_WAIT;
            ACT_SIGNAL: begin
              state_nxt = S_SIG;
              if (in_ch.release_count == 16'sd0) begin
                count_nxt = sat16(18'(count_r) + 18'sd1);
                left_nxt  = ((count_r < 16'sd0) && (wc_r != '0)) ? CW'(1) : '0;
              end else if (in_ch.release_count > 16'sd0) begin
                count_nxt = sat16(18'(count_r) + 18'(in_ch.release_count));
                left_nxt  = (in_ch.release_count >= 16'(wc_r)) ? wc_r
                                                               : CW'(in_ch.release_count);
                ret_nxt   = (in_ch.release_count >= 16'(wc_r)) ? 16'(wc_r)
                                                               : in_ch.release_count;
              end else begin
                ret_nxt = in_ch.release_count;
              end
            end
            ACT_TICK: state_nxt = S_TDEC;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_WAIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_id      = 8'(id_r);
          e_last    = 1'b1;
          state_nxt = S_IDLE;
          if (count_r > 16'sd0) begin
            e_kind    = KIND_ACQ;
            count_nxt = count_r - 16'sd1;
          end else if (wc_r >= CW'(QUEUE_DEPTH)) begin
            e_kind = KIND_FULL;
          end else begin
            e_kind    = KIND_BLOCK;
            count_nxt = sat16(18'(count_r) - 18'sd1);
            cmd       = '{op: OP_LOAD, tail: TAIL_W'(wc_r)};
            wc_nxt    = wc_r + CW'(1);
          end
        end
      end
      S_SIG: begin
        if (left_r == '0) begin
          state_nxt = S_DONE;
        end else if (slot_free) begin
          emit     = 1'b1;
          e_kind   = KIND_SIG;
          e_id     = 8'(id_a[0]);
          cmd      = '{op: OP_POP, tail: '0};
          wc_nxt   = wc_r - CW'(1);
          left_nxt = left_r - CW'(1);
        end
      end
      S_TDEC: begin
        cmd       = '{op: OP_DEC, tail: '0};
        state_nxt = S_TCNT;
      end
      S_TCNT: begin
        count_nxt = sat16(18'(count_r) + 18'($countones(exp_vec)));
        left_nxt  = wc_r;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (left_r == '0) begin
          state_nxt = S_DONE;
        end else if (exp_a[0]) begin
          if (slot_free) begin
            // drop the expired head
            emit     = 1'b1;
            e_kind   = KIND_TIME;
            e_id     = 8'(id_a[0]);
            cmd      = '{op: OP_POP, tail: '0};
            wc_nxt   = wc_r - CW'(1);
            left_nxt = left_r - CW'(1);
          end
        end else begin
          // move the surviving head behind the queue
          cmd      = '{op: OP_ROT, tail: TAIL_W'(wc_r - CW'(1))};
          left_nxt = left_r - CW'(1);
        end
      end
      S_DONE: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_kind    = KIND_DONE;
          e_ret     = ret_r;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_wr) begin
      count_nxt = cfg_pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      init_r      <= 16'sd1;
      count_r     <= 16'sd1;
      wc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      wc_r    <= wc_nxt;
      if (cfg_wr) begin
        init_r <= cfg_pwdata[15:0];
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    ret_r  <= ret_nxt;
    if (accept) begin
      id_r  <= ID_BITS'(in_ch.thread_id);
      tmo_r <= in_ch.timeout_ticks;
    end
    if (emit) begin
      kind_r <= e_kind;
      rid_r  <= e_id;
      oret_r <= e_ret;
      ocnt_r <= count_nxt;
      last_r <= e_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.released_id  = rid_r;
  assign out_ch.return_value = oret_r;
  assign out_ch.count_now    = ocnt_r;
  assign out_ch.last         = last_r;

endmodule

### sim/tb_timed_counting_semaphore.sv
// ----------------------------------------------------------------------------
// tb_timed_counting_semaphore
// Drives wait, signal, tick and undefined items under random idling; models
// the count and queue of waiters; checks every result item field by field.
// ----------------------------------------------------------------------------
module tb_timed_counting_semaphore
  import tcs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         id;
    logic signed [15:0] ret;
    logic signed [15:0] cnt;
    logic               last;
  } sem_result_t;

  typedef struct {
    logic [1:0]         action;
    logic [7:0]         tid;
    logic [15:0]        tmo;
    logic signed [15:0] n;
    bit                 typed;
    logic [2:0]         kind;
    logic signed [15:0] cnt;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  tcs_in_if in_ch();
  tcs_out_if out_ch();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_WAIT;
    in_ch.thread_id = '0;
    in_ch.timeout_ticks = '0;
    in_ch.release_count = '0;
    out_ch.ready = 1'b0;
  end

  timed_counting_semaphore DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // semaphore model
  logic signed [15:0] sem_count;
  logic [7:0]         q_id[DEPTH];
  logic [16:0]        q_tmr[DEPTH];
  int                 q_len;
  sem_result_t        pending[$];
  int                 errors = 0;
  int                 cycles = 0;
  int                 stall_left = 0;
  bit                 stall_on = 1'b1;

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 30);
    return $urandom_range(0, 3);
  endfunction

  task automatic push_result(logic [2:0] k, logic [7:0] id, logic signed [15:0] r,
                             logic l);
    sem_result_t e;
    e.kind = k; e.id = id; e.ret = r; e.cnt = '0; e.last = l;
    pending.insert(pending.size(), e);
  endtask

  task automatic drop_waiter(int pos);
    for (int i = pos; i < q_len - 1; i++) begin
      q_id[i] = q_id[i+1];
      q_tmr[i] = q_tmr[i+1];
    end
    q_len--;
  endtask

  // append the expected results of one accepted item
  task automatic predict_item(logic [1:0] act, logic [7:0] tid, logic [15:0] tmo,
                              logic signed [15:0] n);
    int first;
    int rel;
    int pos;
    first = pending.size();
    if (act == ACT_WAIT) begin
      if (sem_count > 0) begin
        sem_count = clamp16(sem_count - 1);
        push_result(KIND_ACQ, tid, 0, 1'b1);
      end else if (q_len >= DEPTH) begin
        push_result(KIND_FULL, tid, 0, 1'b1);
      end else begin
        sem_count = clamp16(sem_count - 1);
        q_id[q_len] = tid;
        q_tmr[q_len] = (tmo == 0) ? TMR_UNLIMITED : {1'b0, tmo};
        q_len++;
        push_result(KIND_BLOCK, tid, 0, 1'b1);
      end
    end else if (act == ACT_SIGNAL) begin
      if (n == 0) begin
        if (sem_count < 0 && q_len > 0) begin
          push_result(KIND_SIG, q_id[0], 0, 1'b0);
          drop_waiter(0);
        end
        sem_count = clamp16(sem_count + 1);
        push_result(KIND_DONE, 8'd0, 0, 1'b1);
      end else if (n > 0) begin
        rel = 0;
        sem_count = clamp16(int'(sem_count) + int'(n));
        while (rel < n && q_len > 0) begin
          push_result(KIND_SIG, q_id[0], 0, 1'b0);
          drop_waiter(0);
          rel++;
        end
        push_result(KIND_DONE, 8'd0, rel[15:0], 1'b1);
      end else begin
        push_result(KIND_DONE, 8'd0, n, 1'b1);
      end
    end else if (act == ACT_TICK) begin
      pos = 0;
      while (pos < q_len) begin
        if (q_tmr[pos] == TMR_UNLIMITED) begin
          pos++;
        end else begin
          q_tmr[pos] = q_tmr[pos] - 17'd1;
          if (q_tmr[pos] == 0) begin
            push_result(KIND_TIME, q_id[pos], 0, 1'b0);
            drop_waiter(pos);
            sem_count = clamp16(sem_count + 1);
          end else begin
            pos++;
          end
        end
      end
      push_result(KIND_DONE, 8'd0, 0, 1'b1);
    end else begin
      push_result(KIND_DONE, 8'd0, 0, 1'b1);
    end
    for (int i = first; i < pending.size(); i++) pending[i].cnt = sem_count;
  endtask

  task automatic report_mismatch(string what);
    errors++;
    $display("MISMATCH at cycle %0d: %s", cycles, what);
  endtask

  // result monitor
  always @(posedge clk) begin
    sem_result_t e;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", out_ch.kind));
      end else begin
        e = pending.pop_front();
        if (out_ch.kind !== e.kind || out_ch.released_id !== e.id ||
            out_ch.return_value !== e.ret || out_ch.count_now !== e.cnt ||
            out_ch.last !== e.last)
          report_mismatch($sformatf(
            "got k%0d id%0d r%0d c%0d l%0d, want k%0d id%0d r%0d c%0d l%0d",
            out_ch.kind, out_ch.released_id, out_ch.return_value, out_ch.count_now,
            out_ch.last, e.kind, e.id, e.ret, e.cnt, e.last));
      end
    end
  end

  // result-side stall: mostly short, now and then a long one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (!stall_on) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 40) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(8, 30);
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      report_mismatch($sformatf("timeout with %0d results outstanding", pending.size()));
      $display("tb_timed_counting_semaphore: errors");
      $finish;
    end
  end

  task automatic cfg_write(logic signed [15:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {CFG_IDX_INIT, 2'b00};
    cfg_pwdata <= {{16{v[15]}}, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    sem_count = v;
  endtask

  task automatic send_item(logic [1:0] act, logic [7:0] tid, logic [15:0] tmo,
                           logic signed [15:0] n);
    int gap;
    gap = pick_gap();
    // step off the edge that dropped valid for the previous item
    repeat (gap + 1) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.thread_id <= tid;
    in_ch.timeout_ticks <= tmo;
    in_ch.release_count <= n;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(act, tid, tmo, n);
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic stim_row_t mk(logic [1:0] a, logic [7:0] t, logic [15:0] o,
                                   logic signed [15:0] n, bit ty = 0,
                                   logic [2:0] k = 0, logic signed [15:0] c = 0);
    stim_row_t r;
    r.action = a; r.tid = t; r.tmo = o; r.n = n; r.typed = ty; r.kind = k; r.cnt = c;
    return r;
  endfunction

  stim_row_t rows[$];

  task automatic random_phase(int items);
    int pick;
    logic [15:0] tmo;
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      tmo = ($urandom_range(0, 3) == 0) ? 16'd0 :
            ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
      if (pick < 45)
        send_item(ACT_WAIT, 8'($urandom), tmo, 16'($urandom));
      else if (pick < 65)
        send_item(ACT_SIGNAL, 8'($urandom), 16'($urandom),
                  ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                  16'($urandom_range(0, 4)));
      else if (pick < 97)
        send_item(ACT_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
      else
        send_item(2'd3, 8'($urandom), 16'($urandom), 16'($urandom));
      if ($urandom_range(0, 30) == 0) begin
        stall_on = 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
        stall_on = 1'b1;
      end
    end
  endtask

  initial begin
    sem_result_t e;
    sem_count = 16'sd1;
    q_len = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, starting from the reset count of one
    rows.insert(rows.size(), mk(ACT_WAIT, 8'hff, 16'd0, 0, 1, KIND_ACQ, 16'sd0));
    rows.insert(rows.size(), mk(ACT_WAIT, 8'h00, 16'd0, 0, 1, KIND_BLOCK, -16'sd1));
    rows.insert(rows.size(), mk(ACT_WAIT, 8'h5a, 16'd1, 0, 1, KIND_BLOCK, -16'sd2));
    rows.insert(rows.size(), mk(ACT_WAIT, 8'ha5, 16'hffff, 0));
    rows.insert(rows.size(), mk(ACT_TICK, 8'h00, 16'd0, 0));
    rows.insert(rows.size(), mk(ACT_SIGNAL, 8'h00, 16'd0, 16'sh8000));
    rows.insert(rows.size(), mk(ACT_SIGNAL, 8'h00, 16'd0, 16'sd0));
    rows.insert(rows.size(), mk(ACT_SIGNAL, 8'h00, 16'd0, 16'sh7fff));
    rows.insert(rows.size(), mk(ACT_TICK, 8'h00, 16'd0, 0));
    rows.insert(rows.size(), mk(2'd3, 8'hff, 16'hffff, 16'shffff));
    rows.insert(rows.size(), mk(ACT_SIGNAL, 8'h00, 16'd0, 16'sd0));
    foreach (rows[i]) begin
      send_item(rows[i].action, rows[i].tid, rows[i].tmo, rows[i].n);
      if (rows[i].typed) begin
        e = pending[pending.size()-1];
        if (e.kind !== rows[i].kind || e.cnt !== rows[i].cnt)
          report_mismatch($sformatf("directed row %0d table disagrees", i));
      end
    end
    drain();

    // fill the queue past full from one above the most negative count
    cfg_write(16'sh8001);
    for (int i = 0; i < 18; i++) send_item(ACT_WAIT, 8'(i * 13), 16'(i % 3), 0);
    send_item(ACT_TICK, 0, 0, 0);
    send_item(ACT_TICK, 0, 0, 0);
    send_item(ACT_SIGNAL, 0, 0, 16'sd20);
    drain();

    cfg_write(16'sh7fff);
    send_item(ACT_SIGNAL, 0, 0, 16'sd5);
    send_item(ACT_SIGNAL, 0, 0, 16'sd0);
    random_phase(10);
    drain();

    cfg_write(16'sd0);
    random_phase(60);
    drain();

    cfg_write(-16'sd3);
    random_phase(60);
    drain();

    if (errors == 0) begin
      $display("tb_timed_counting_semaphore: clean");
    end else begin
      $display("tb_timed_counting_semaphore: errors");
    end
    $finish;
  end

endmodule

### filelist.f
src/tcs_pkg.sv
src/tcs_in_if.sv
src/tcs_out_if.sv
src/tcs_cell.sv
src/timed_counting_semaphore.sv
sim/tb_timed_counting_semaphore.sv
